@@ sv/cfs_pkg.sv @@
// Package for the CSV field splitter: request and result types,
// configuration register indexes and field widths. No dependencies.
package cfs_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned NumW  = 13;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUOTE = 2'd0,
    CFG_DELIM = 2'd1,
    CFG_TRIM  = 2'd2
  } cfg_idx_e;

  localparam logic [ByteW-1:0] QuoteReset = 8'd34;
  localparam logic [ByteW-1:0] DelimReset = 8'd44;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [NumW-1:0] field_number;
    logic [NumW-1:0] keep_start;
    logic [NumW-1:0] field_length;
    logic            row_done;
    logic            line_overflow;
  } out_item_t;

endpackage

@@ sv/csv_field_splitter_unit.sv @@
// Result path: a field result is registered, at the edge that accepts the closing byte or
// end-of-line request: into the output register, offered next cycle, else into the skid.
// Throughput: one request per cycle; a two-entry result stage (output register
// plus skid) lets requests flow while a result waits; input stalls only when both hold one.
// Reset: line state cleared, quote 34, delimiter 44, trimming off, no result pending.
// Depends on cfs_pkg.
module csv_field_splitter_unit #(
  parameter int unsigned MAX_LINE_BYTES = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cfs_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cfs_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [cfs_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [cfs_pkg::ByteW-1:0]           cfg_data_i
);
  import cfs_pkg::*;

  localparam int unsigned PW = $clog2(MAX_LINE_BYTES + 1);
  localparam logic [PW-1:0] MaxPos = PW'(MAX_LINE_BYTES);
  localparam logic [NumW-1:0] CntMax = {NumW{1'b1}};

  logic [ByteW-1:0] quote_q, delim_q;
  logic             trim_q;

  logic            quoted_q, quoted_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [PW-1:0]   begin_q, begin_d;
  logic [PW-1:0]   fnb_q, fnb_d, fni_q, fni_d, lnb_q, lnb_d, plnb_q, plnb_d;
  logic            fnb_v_q, fnb_v_d, fni_v_q, fni_v_d, lnb_v_q, lnb_v_d;
  logic            plnb_v_q, plnb_v_d;
  logic            fiq_q, fiq_d, liq_q, liq_d;
  logic [NumW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;

  out_item_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;

  logic       accept, pop, push;
  logic [7:0] b;
  logic       eol, is_q, is_d, blank;

  logic [PW-1:0] len, lo, hi, f_pos, l_pos, e_start, e_len;
  logic          strip1, strip2, stripped, f_ok, l_ok;
  out_item_t     res;

  assign accept = in_valid_i && !in_stall_o;
  assign pop    = out_valid_q && !out_stall_i;
  assign b      = in_data_i.data_byte;
  assign eol    = in_data_i.end_of_line;
  assign is_q   = (b == quote_q);
  assign is_d   = (b == delim_q);
  assign blank  = (b == 8'd32) || (b inside {[8'd9:8'd13]});

  // field boundary for [begin_q, pos_q)
  always_comb begin
    len      = pos_q - begin_q;
    strip1   = (len == PW'(1)) && fiq_q;
    strip2   = (len >= PW'(2)) && fiq_q && liq_q;
    stripped = strip1 || strip2;
    lo       = stripped ? begin_q + PW'(1) : begin_q;
    hi       = strip1 ? begin_q + PW'(1) : (strip2 ? pos_q - PW'(1) : pos_q);
    if (stripped) begin
      f_pos = fni_q;
      l_pos = plnb_q;
      f_ok  = fni_v_q && (fni_q < hi);
      l_ok  = plnb_v_q && (plnb_q >= lo);
    end else begin
      f_pos = fnb_q;
      l_pos = lnb_q;
      f_ok  = fnb_v_q;
      l_ok  = lnb_v_q;
    end
    if (lo >= hi) begin
      e_start = hi;
      e_len   = '0;
    end else if (!trim_q) begin
      e_start = lo;
      e_len   = hi - lo;
    end else if (!f_ok || !l_ok || (l_pos < f_pos)) begin
      e_start = hi;
      e_len   = '0;
    end else begin
      e_start = f_pos;
      e_len   = l_pos - f_pos + PW'(1);
    end
    res.field_number  = cnt_q;
    res.keep_start    = NumW'(e_start);
    res.field_length  = NumW'(e_len);
    res.row_done      = eol;
    res.line_overflow = ovf_q;
  end

  always_comb begin
    quoted_d = quoted_q;
    pos_d    = pos_q;
    begin_d  = begin_q;
    fnb_d    = fnb_q;
    fnb_v_d  = fnb_v_q;
    fni_d    = fni_q;
    fni_v_d  = fni_v_q;
    lnb_d    = lnb_q;
    lnb_v_d  = lnb_v_q;
    plnb_d   = plnb_q;
    plnb_v_d = plnb_v_q;
    fiq_d    = fiq_q;
    liq_d    = liq_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    push     = 1'b0;
    if (accept) begin
      if (eol) begin
        push     = (pos_q != '0) || ovf_q;
        quoted_d = 1'b0;
        pos_d    = '0;
        cnt_d    = '0;
        ovf_d    = 1'b0;
        begin_d  = '0;
        fnb_v_d  = 1'b0;
        fni_v_d  = 1'b0;
        lnb_v_d  = 1'b0;
        plnb_v_d = 1'b0;
        fiq_d    = 1'b0;
        liq_d    = 1'b0;
      end else if (pos_q >= MaxPos) begin
        ovf_d = 1'b1;
      end else if (!is_q && is_d && !quoted_q) begin
        push     = 1'b1;
        cnt_d    = (cnt_q < CntMax) ? cnt_q + NumW'(1) : cnt_q;
        begin_d  = pos_q + PW'(1);
        pos_d    = pos_q + PW'(1);
        fnb_v_d  = 1'b0;
        fni_v_d  = 1'b0;
        lnb_v_d  = 1'b0;
        plnb_v_d = 1'b0;
        fiq_d    = 1'b0;
        liq_d    = 1'b0;
      end else begin
        if (is_q) begin
          quoted_d = !quoted_q;
        end
        if (pos_q == begin_q) begin
          fiq_d = is_q;
        end
        liq_d    = is_q;
        plnb_d   = lnb_q;
        plnb_v_d = lnb_v_q;
        if (!blank) begin
          if (!fnb_v_q) begin
            fnb_d   = pos_q;
            fnb_v_d = 1'b1;
          end
          if ((pos_q > begin_q) && !fni_v_q) begin
            fni_d   = pos_q;
            fni_v_d = 1'b1;
          end
          lnb_d   = pos_q;
          lnb_v_d = 1'b1;
        end
        pos_d = pos_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q  <= QuoteReset;
      delim_q  <= DelimReset;
      trim_q   <= 1'b0;
      quoted_q <= 1'b0;
      pos_q    <= '0;
      begin_q  <= '0;
      fnb_v_q  <= 1'b0;
      fni_v_q  <= 1'b0;
      lnb_v_q  <= 1'b0;
      plnb_v_q <= 1'b0;
      fiq_q    <= 1'b0;
      liq_q    <= 1'b0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_QUOTE: quote_q <= cfg_data_i;
          CFG_DELIM: delim_q <= cfg_data_i;
          CFG_TRIM:  trim_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      quoted_q <= quoted_d;
      pos_q    <= pos_d;
      begin_q  <= begin_d;
      fnb_v_q  <= fnb_v_d;
      fni_v_q  <= fni_v_d;
      lnb_v_q  <= lnb_v_d;
      plnb_v_q <= plnb_v_d;
      fiq_q    <= fiq_d;
      liq_q    <= liq_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fnb_q  <= fnb_d;
    fni_q  <= fni_d;
    lnb_q  <= lnb_d;
    plnb_q <= plnb_d;
  end

  // result register and skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ test/tb_top.sv @@
// Testbench for csv_field_splitter_unit: directed and random CSV lines under random
// valid/stall gaps, checked field by field against an in-bench tokenizer model.
// Depends on cfs_pkg and csv_field_splitter_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cfs_pkg::*;

  localparam int LineMax = 4096;
  localparam int NoPos = -1;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [ByteW-1:0]   cfg_data_i = '0;

  csv_field_splitter_unit #(.MAX_LINE_BYTES(LineMax)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Tokenizer model state
  logic [ByteW-1:0] quote_reg = QuoteReset;
  logic [ByteW-1:0] delim_reg = DelimReset;
  bit               trim_reg = 1'b0;
  bit               quote_open;
  int               pos, fld_begin, fnb, fnb_inner, lnb, lnb_prev;
  bit               first_q, latest_q, line_ovf;
  logic [NumW-1:0]  fld_cnt;

  out_item_t fields_due[$];
  int        mismatches = 0;
  int        sent = 0;
  bit        no_idle = 1'b0;
  int        stall_left = 0;

  function automatic bit is_blank(logic [ByteW-1:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic void restart_field(int from);
    fld_begin = from;
    fnb = NoPos;
    fnb_inner = NoPos;
    lnb = NoPos;
    lnb_prev = NoPos;
    first_q = 1'b0;
    latest_q = 1'b0;
  endfunction

  function automatic void restart_line();
    quote_open = 1'b0;
    pos = 0;
    fld_cnt = '0;
    line_ovf = 1'b0;
    restart_field(0);
  endfunction

  function automatic out_item_t close_field(int stop, bit last);
    int        a, b, f, l, first, klen;
    bit        stripped;
    out_item_t r;
    a = fld_begin;
    b = stop;
    stripped = 1'b0;
    if (stop - fld_begin == 1 && first_q) begin
      a = fld_begin + 1;
      b = fld_begin + 1;
      stripped = 1'b1;
    end else if (stop - fld_begin >= 2 && first_q && latest_q) begin
      a = fld_begin + 1;
      b = stop - 1;
      stripped = 1'b1;
    end
    if (a >= b) begin
      first = b;
      klen = 0;
    end else if (!trim_reg) begin
      first = a;
      klen = b - a;
    end else begin
      if (stripped) begin
        f = (fnb_inner != NoPos && fnb_inner < b) ? fnb_inner : NoPos;
        l = (lnb_prev != NoPos && lnb_prev >= a) ? lnb_prev : NoPos;
      end else begin
        f = fnb;
        l = lnb;
      end
      if (f == NoPos || l == NoPos || l < f) begin
        first = b;
        klen = 0;
      end else begin
        first = f;
        klen = l - f + 1;
      end
    end
    r.field_number  = fld_cnt;
    r.keep_start    = NumW'(first);
    r.field_length  = NumW'(klen);
    r.row_done      = last;
    r.line_overflow = line_ovf;
    if (fld_cnt != '1) fld_cnt++;
    return r;
  endfunction

  function automatic void tokenize_byte(in_item_t req);
    logic [ByteW-1:0] b;
    b = req.data_byte;
    if (req.end_of_line) begin
      if (pos != 0 || line_ovf) fields_due.push_back(close_field(pos, 1'b1));
      restart_line();
    end else if (pos >= LineMax) begin
      line_ovf = 1'b1;
    end else if (b != quote_reg && b == delim_reg && !quote_open) begin
      fields_due.push_back(close_field(pos, 1'b0));
      restart_field(pos + 1);
      pos++;
    end else begin
      if (b == quote_reg) quote_open = !quote_open;
      if (pos == fld_begin) first_q = (b == quote_reg);
      latest_q = (b == quote_reg);
      lnb_prev = lnb;
      if (!is_blank(b)) begin
        if (fnb == NoPos) fnb = pos;
        if (pos > fld_begin && fnb_inner == NoPos) fnb_inner = pos;
        lnb = pos;
      end
      pos++;
    end
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk_i) begin
    bit hold;
    if (stall_left > 0) begin
      stall_left--;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else begin
      hold = ($urandom_range(0, 2) == 0);
      out_stall_i <= hold;
      stall_left = hold ? gap_len() : $urandom_range(0, 6);
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fields_due.size() == 0) begin
        report_mismatch("unexpected field", out_data_o.field_number, -1);
      end else begin
        want = fields_due.pop_front();
        if (out_data_o.field_number !== want.field_number)
          report_mismatch("field_number", out_data_o.field_number, want.field_number);
        if (out_data_o.keep_start !== want.keep_start)
          report_mismatch("keep_start", out_data_o.keep_start, want.keep_start);
        if (out_data_o.field_length !== want.field_length)
          report_mismatch("field_length", out_data_o.field_length, want.field_length);
        if (out_data_o.row_done !== want.row_done)
          report_mismatch("row_done", out_data_o.row_done, want.row_done);
        if (out_data_o.line_overflow !== want.line_overflow)
          report_mismatch("line_overflow", out_data_o.line_overflow, want.line_overflow);
      end
    end
  end

  task automatic send_req(in_item_t req);
    int gap;
    gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    tokenize_byte(req);
    sent++;
  endtask

  task automatic send_byte(logic [ByteW-1:0] b);
    in_item_t req;
    req.data_byte = b;
    req.end_of_line = 1'b0;
    send_req(req);
  endtask

  task automatic send_eol();
    in_item_t req;
    req.data_byte = 8'($urandom_range(0, 255));
    req.end_of_line = 1'b1;
    send_req(req);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (fields_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [ByteW-1:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_QUOTE: quote_reg = val;
      CFG_DELIM: delim_reg = val;
      CFG_TRIM:  trim_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [ByteW-1:0] q, logic [ByteW-1:0] d, bit t);
    write_reg(CFG_QUOTE, q);
    write_reg(CFG_DELIM, d);
    write_reg(CFG_TRIM, {7'd0, t});
  endtask

  function automatic logic [ByteW-1:0] pick_text_byte(bit allow_delim);
    logic [ByteW-1:0] b;
    do begin
      case ($urandom_range(0, 9))
        0, 1:    b = 8'd32;
        2:       b = 8'($urandom_range(9, 13));
        3:       b = 8'($urandom_range(0, 255));
        default: b = 8'($urandom_range(33, 126));
      endcase
    end while (b == quote_reg || (!allow_delim && b == delim_reg));
    return b;
  endfunction

  task automatic send_random_line();
    int kind;
    bit pad;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(0, 12)) begin
        case ($urandom_range(0, 3))
          0:       send_byte(quote_reg);
          1:       send_byte(delim_reg);
          default: send_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      for (int k = 0; k < $urandom_range(1, 5); k++) begin
        if (k > 0) send_byte(delim_reg);
        kind = $urandom_range(0, 3);
        pad = (kind == 3) || ($urandom_range(0, 3) == 0);
        if (pad) repeat ($urandom_range(0, 2)) send_byte(8'd32);
        if (kind == 0) begin
          repeat ($urandom_range(0, 6)) send_byte(pick_text_byte(1'b0));
        end else if (kind != 1) begin
          send_byte(quote_reg);
          repeat ($urandom_range(0, 5)) send_byte(pick_text_byte(1'b1));
          send_byte(quote_reg);
        end
        if (pad) repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(9, 13)));
      end
    end
    send_eol();
  endtask

  task automatic test_default_lines();
    send_eol();
    send_text("\"");
    send_eol();
    send_text(",");
    send_eol();
    send_text("\"a,b");
    send_eol();
    send_byte(8'd0);
    send_byte(8'd255);
    send_byte(DelimReset);
    send_eol();
  endtask

  task automatic test_trim_lines();
    set_config(8'd34, 8'd44, 1'b1);
    send_text("\" x \", y ,  ");
    send_eol();
    set_config(8'd32, 8'd44, 1'b1);
    send_text("  a ,b");
    send_eol();
    set_config(8'd44, 8'd44, 1'b0);
    send_text("a,b");
    send_eol();
  endtask

  task automatic test_reg_change_mid_line();
    set_config(8'd34, 8'd44, 1'b0);
    send_text("ab\" c");
    write_reg(CFG_TRIM, 8'd1);
    write_reg(CFG_QUOTE, 8'd39);
    send_text("' d ',\" e");
    send_eol();
  endtask

  task automatic test_long_lines();
    set_config(QuoteReset, DelimReset, 1'b1);
    no_idle = 1'b1;
    for (int i = 0; i < LineMax + 4; i++)
      send_byte((i == LineMax - 1 || i % 700 == 0) ? delim_reg : pick_text_byte(1'b0));
    send_eol();
    for (int i = 0; i < LineMax; i++)
      send_byte((i == 0 || i == LineMax - 1) ? quote_reg : pick_text_byte(1'b1));
    send_eol();
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_phase(logic [ByteW-1:0] q, logic [ByteW-1:0] d, bit t,
                                   bit calm);
    int first;
    set_config(q, d, t);
    no_idle = calm;
    first = sent;
    while (sent - first < 260) begin
      send_random_line();
      if ($urandom_range(0, 39) == 0) wait_idle();
    end
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_lines();
    logic [ByteW-1:0] r;
    r = 8'($urandom_range(0, 255));
    test_random_phase(8'd34, 8'd44, 1'b0, 1'b0);
    test_random_phase(8'd34, 8'd44, 1'b1, 1'b0);
    test_random_phase(8'd0, 8'd255, 1'b1, 1'b1);
    test_random_phase(8'd255, 8'd0, 1'b0, 1'b0);
    test_random_phase(r, r, 1'b1, 1'b0);
    test_random_phase(8'd32, 8'd9, 1'b1, 1'b0);
    test_random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'b0);
  endtask

  initial begin
    restart_line();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_lines();
    test_trim_lines();
    test_reg_change_mid_line();
    test_long_lines();
    test_random_lines();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
